### rtl/core/tbgw_pkg.sv
// Package for the two-body grid warp unit: widths, register indexes,
// reset values and the side-channel word type; the widths are shared by all modules.
// Depends on nothing.
`default_nettype none

package tbgw_pkg;

  localparam int COORD_FRAC_BITS = 8;
  localparam int COORD_W         = 24;
  localparam int DIFF_W          = COORD_W + 1;
  localparam int SQ_W            = 2 * DIFF_W;
  localparam int ROOT_W          = SQ_W / 2;
  localparam int REM_W           = ROOT_W + 2;
  localparam int FALL_W          = 16;
  localparam int DIST_W          = FALL_W + COORD_FRAC_BITS;
  localparam int STR_W           = 16;
  localparam int NUM_W           = STR_W + DIST_W;
  localparam int PROD_W          = DIFF_W + STR_W + 1;
  localparam int SUM_W           = PROD_W + 1;
  localparam int SQRT_STAGES     = ROOT_W;
  localparam int DIV_STAGES      = STR_W;
  // Side data travels from the difference stage to the strength output.
  localparam int SIDE_DEPTH      = 3 + SQRT_STAGES + 2 + DIV_STAGES;
  localparam int PIPE_DEPTH      = SIDE_DEPTH + 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;
  localparam int TDATA_W         = 2 * COORD_W;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [COORD_W-1:0] RST_FIRST_X  = 24'd204800;
  localparam logic [COORD_W-1:0] RST_FIRST_Y  = 24'd128000;
  localparam logic [COORD_W-1:0] RST_SECOND_X = 24'd303206;
  localparam logic [COORD_W-1:0] RST_SECOND_Y = 24'd128000;
  localparam logic [FALL_W-1:0]  RST_FALLOFF  = 16'd3000;
  localparam logic [STR_W-1:0]   RST_PEAK     = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_X  = 3'd0,
    REG_FIRST_Y  = 3'd1,
    REG_SECOND_X = 3'd2,
    REG_SECOND_Y = 3'd3,
    REG_FALLOFF  = 3'd4,
    REG_PEAK     = 3'd5
  } cfg_reg_t;

  // Vertex and body offsets carried alongside the distance math.
  typedef struct packed {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [DIFF_W-1:0]  dx1;
    logic signed [DIFF_W-1:0]  dy1;
    logic signed [DIFF_W-1:0]  dx2;
    logic signed [DIFF_W-1:0]  dy2;
  } side_t;

endpackage

`default_nettype wire

### rtl/core/two_body_grid_warp_unit.sv
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output word waits. Most of the depth lies in the 25-stage root and 16-stage divider.
// Reset (rst, synchronous): clears all valid bits and loads the register
// defaults; the first input word can be taken the cycle after reset drops.
// Depends on tbgw_pkg, tbgw_sqrt and tbgw_div.
`default_nettype none

module two_body_grid_warp_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_wr_en,
  input  wire  [tbgw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [tbgw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: vertex_x[23:0], vertex_y[47:24].
  input  wire  [tbgw_pkg::TDATA_W-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // Fields from bit 0: warped_x[23:0], warped_y[47:24].
  output logic [tbgw_pkg::TDATA_W-1:0]     m_axis_tdata
);
  import tbgw_pkg::*;

  // Configuration registers.
  logic signed [COORD_W-1:0] first_x, first_y, second_x, second_y;
  logic [FALL_W-1:0]         falloff;
  logic [STR_W-1:0]          peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_x  <= RST_FIRST_X;
      first_y  <= RST_FIRST_Y;
      second_x <= RST_SECOND_X;
      second_y <= RST_SECOND_Y;
      falloff  <= RST_FALLOFF;
      peak     <= RST_PEAK;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FIRST_X:  first_x  <= cfg_data[COORD_W-1:0];
        REG_FIRST_Y:  first_y  <= cfg_data[COORD_W-1:0];
        REG_SECOND_X: second_x <= cfg_data[COORD_W-1:0];
        REG_SECOND_Y: second_y <= cfg_data[COORD_W-1:0];
        REG_FALLOFF:  falloff  <= cfg_data[FALL_W-1:0];
        REG_PEAK:     peak     <= cfg_data[STR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIST_W-1:0] dfall;
  assign dfall = {falloff, {COORD_FRAC_BITS{1'b0}}};

  // Global advance: every stage moves unless the output word is stalled.
  logic en;
  logic vld [PIPE_DEPTH];
  assign en            = !vld[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIPE_DEPTH; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int k = 1; k < PIPE_DEPTH; k++) vld[k] <= vld[k-1];
    end
  end

  // Stage 0: offsets from the vertex to each body.
  logic signed [COORD_W-1:0] in_x, in_y;
  side_t side_next;
  side_t side [SIDE_DEPTH];
  assign in_x = s_axis_tdata[COORD_W-1:0];
  assign in_y = s_axis_tdata[TDATA_W-1:COORD_W];

  always_comb begin
    side_next.vx  = in_x;
    side_next.vy  = in_y;
    side_next.dx1 = DIFF_W'(first_x)  - DIFF_W'(in_x);
    side_next.dy1 = DIFF_W'(first_y)  - DIFF_W'(in_y);
    side_next.dx2 = DIFF_W'(second_x) - DIFF_W'(in_x);
    side_next.dy2 = DIFF_W'(second_y) - DIFF_W'(in_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_next;
      for (int k = 1; k < SIDE_DEPTH; k++) side[k] <= side[k-1];
    end
  end

  // Stage 1: squares; stage 2: squared lengths.
  logic [SQ_W-1:0] sqx1, sqy1, sqx2, sqy2, len1, len2;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx1 <= SQ_W'(side[0].dx1 * side[0].dx1);
      sqy1 <= SQ_W'(side[0].dy1 * side[0].dy1);
      sqx2 <= SQ_W'(side[0].dx2 * side[0].dx2);
      sqy2 <= SQ_W'(side[0].dy2 * side[0].dy2);
      len1 <= sqx1 + sqy1;
      len2 <= sqx2 + sqy2;
    end
  end

  // Lengths by pipelined root.
  logic [ROOT_W-1:0] dist1, dist2;
  tbgw_sqrt u_sqrt1 (.clk(clk), .en(en), .n_in(len1), .root_out(dist1));
  tbgw_sqrt u_sqrt2 (.clk(clk), .en(en), .n_in(len2), .root_out(dist2));

  // Clamp to the falloff, then the strength numerator.
  logic [DIST_W-1:0] clamp1, clamp2;
  logic [NUM_W-1:0]  num1, num2;
  always_ff @(posedge clk) begin
    if (en) begin
      clamp1 <= (dist1 < ROOT_W'(dfall)) ? DIST_W'(dist1) : dfall;
      clamp2 <= (dist2 < ROOT_W'(dfall)) ? DIST_W'(dist2) : dfall;
      num1   <= NUM_W'(peak) * NUM_W'(dfall - clamp1);
      num2   <= NUM_W'(peak) * NUM_W'(dfall - clamp2);
    end
  end

  logic [STR_W-1:0] quo1, quo2, str1, str2;
  tbgw_div u_div1 (.clk(clk), .en(en), .num_in(num1), .den_in(dfall), .quo_out(quo1));
  tbgw_div u_div2 (.clk(clk), .en(en), .num_in(num2), .den_in(dfall), .quo_out(quo2));

  // A zero falloff gives no pull at all.
  assign str1 = (falloff == '0) ? '0 : quo1;
  assign str2 = (falloff == '0) ? '0 : quo2;

  // Offsets scaled by strength.
  logic signed [PROD_W-1:0]  px1, py1, px2, py2;
  logic signed [COORD_W-1:0] pvx, pvy;
  side_t                     sd;
  assign sd = side[SIDE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= sd.dx1 * $signed({1'b0, str1});
      py1 <= sd.dy1 * $signed({1'b0, str1});
      px2 <= sd.dx2 * $signed({1'b0, str2});
      py2 <= sd.dy2 * $signed({1'b0, str2});
      pvx <= sd.vx;
      pvy <= sd.vy;
    end
  end

  // Sum with the rounding half, kept at full width.
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (STR_W - 1);
  logic signed [SUM_W-1:0] sumx, sumy;
  always_ff @(posedge clk) begin
    if (en) begin
      sumx <= (SUM_W'(pvx) <<< STR_W) + SUM_W'(px1) + SUM_W'(px2) + HALF;
      sumy <= (SUM_W'(pvy) <<< STR_W) + SUM_W'(py1) + SUM_W'(py2) + HALF;
    end
  end

  // Round down to coordinate units and saturate.
  function automatic logic [COORD_W-1:0] sat(logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-STR_W-1:0] q;
    q = s[SUM_W-1:STR_W];
    if (q > (SUM_W-STR_W)'(COORD_MAX)) return COORD_MAX;
    if (q < (SUM_W-STR_W)'(COORD_MIN)) return COORD_MIN;
    return q[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {sat(sumy), sat(sumx)};
    end
  end

endmodule

`default_nettype wire

### rtl/core/tbgw_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on tbgw_pkg.
`default_nettype none

module tbgw_sqrt (
  input  wire                          clk,
  input  wire                          en,
  input  wire  [tbgw_pkg::SQ_W-1:0]    n_in,
  output logic [tbgw_pkg::ROOT_W-1:0]  root_out
);
  import tbgw_pkg::*;

  typedef struct packed {
    logic [SQ_W-1:0]   n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_stage_t;

  sq_stage_t stg      [SQRT_STAGES];
  sq_stage_t stg_next [SQRT_STAGES];

  // One digit: bring in two bits of the radicand and try a root bit of one.
  function automatic sq_stage_t sq_step(sq_stage_t s);
    sq_stage_t          r;
    logic [REM_W-1:0]   acc;
    logic [REM_W-1:0]   trial;
    acc   = {s.rem[REM_W-3:0], s.n[SQ_W-1:SQ_W-2]};
    trial = {s.root, 2'b01};
    r.n   = {s.n[SQ_W-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Next value of every stage from the stage before it.
  always_comb begin
    stg_next[0] = sq_step('{n: n_in, rem: '0, root: '0});
    for (int k = 1; k < SQRT_STAGES; k++) begin
      stg_next[k] = sq_step(stg[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  assign root_out = stg[SQRT_STAGES-1].root;

endmodule

`default_nettype wire

### rtl/core/tbgw_div.sv
// Pipelined restoring divider for the strength quotient, one bit per stage.
// Depends on tbgw_pkg.
`default_nettype none

module tbgw_div (
  input  wire                          clk,
  input  wire                          en,
  input  wire  [tbgw_pkg::NUM_W-1:0]   num_in,
  input  wire  [tbgw_pkg::DIST_W-1:0]  den_in,
  output logic [tbgw_pkg::STR_W-1:0]   quo_out
);
  import tbgw_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [DIST_W-1:0] den;
    logic [STR_W-1:0]  quo;
  } dv_stage_t;

  dv_stage_t stg      [DIV_STAGES];
  dv_stage_t stg_next [DIV_STAGES];

  // Subtract the divisor shifted to the bit under test when it fits.
  function automatic dv_stage_t dv_step(dv_stage_t s, int sh);
    dv_stage_t        r;
    logic [NUM_W-1:0] dsh;
    logic             ge;
    dsh   = NUM_W'(s.den) << sh;
    ge    = (s.rem >= dsh);
    r.den = s.den;
    r.rem = ge ? (s.rem - dsh) : s.rem;
    r.quo = {s.quo[STR_W-2:0], ge};
    return r;
  endfunction

  // The quotient is below 2^STR_W, so the highest bit tried is STR_W-1.
  always_comb begin
    stg_next[0] = dv_step('{rem: num_in, den: den_in, quo: '0}, STR_W - 1);
    for (int k = 1; k < DIV_STAGES; k++) begin
      stg_next[k] = dv_step(stg[k-1], STR_W - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  assign quo_out = stg[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

### rtl/core/tbgw_checker.sv
// Port-level checks for the two-body grid warp unit, bound to the top level.
// Depends on tbgw_pkg and two_body_grid_warp_unit.
`default_nettype none

module tbgw_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [tbgw_pkg::TDATA_W-1:0]    m_axis_tdata
);
  import tbgw_pkg::*;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid right after reset");

  // With no word waiting at the output the input is always ready.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

  // A stalled output word stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // A stall at the output stalls the input.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

endmodule

bind two_body_grid_warp_unit tbgw_checker u_tbgw_checker (
  .clk(clk),
  .rst(rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

`default_nettype wire

### test/two_body_grid_warp_unit_chk.sv
// Checker for the two-body grid warp unit: mirrors the register writes,
// predicts each warped vertex and compares it with the output stream.
// Depends on tbgw_pkg.
`default_nettype none

module two_body_grid_warp_unit_chk (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_wr_en,
  input  wire  [tbgw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [tbgw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                              s_axis_tvalid,
  input  wire                              s_axis_tready,
  input  wire  [tbgw_pkg::TDATA_W-1:0]     s_axis_tdata,
  input  wire                              m_axis_tvalid,
  input  wire                              m_axis_tready,
  input  wire  [tbgw_pkg::TDATA_W-1:0]     m_axis_tdata,
  output int                               errors,
  output int                               pending
);
  import tbgw_pkg::*;

  logic signed [23:0] body1_x, body1_y, body2_x, body2_y;
  logic [15:0] falloff, peak;
  logic [47:0] warped_q[$];

  // Integer square root, rounded down.
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint pull_strength(longint dx, longint dy);
    longint unsigned d, c, span_len;
    span_len = floor_root(dx * dx + dy * dy);
    d = longint'(falloff) << COORD_FRAC_BITS;
    if (d == 0) return 0;
    c = (span_len < d) ? span_len : d;
    return longint'((longint'(peak) * (d - c)) / d);
  endfunction

  function automatic logic [23:0] warp_coord(longint p, longint d1, longint s1,
                                             longint d2, longint s2);
    longint q;
    q = ((p <<< 16) + d1 * s1 + d2 * s2 + 32768) >>> 16;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return q[23:0];
  endfunction

  function automatic logic [47:0] warp_vertex(logic [47:0] w);
    longint px, py, dx1, dy1, dx2, dy2, s1, s2;
    px = longint'($signed(w[23:0]));
    py = longint'($signed(w[47:24]));
    dx1 = longint'(body1_x) - px;
    dy1 = longint'(body1_y) - py;
    dx2 = longint'(body2_x) - px;
    dy2 = longint'(body2_y) - py;
    s1 = pull_strength(dx1, dy1);
    s2 = pull_strength(dx2, dy2);
    return {warp_coord(py, dy1, s1, dy2, s2), warp_coord(px, dx1, s1, dx2, s2)};
  endfunction

  assign pending = warped_q.size();

  // Track registers, queue predictions and compare output words.
  always @(posedge clk) begin
    logic [47:0] exp_w;
    if (rst) begin
      body1_x <= RST_FIRST_X;
      body1_y <= RST_FIRST_Y;
      body2_x <= RST_SECOND_X;
      body2_y <= RST_SECOND_Y;
      falloff <= RST_FALLOFF;
      peak <= RST_PEAK;
      errors <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FIRST_X: body1_x <= cfg_data;
          REG_FIRST_Y: body1_y <= cfg_data;
          REG_SECOND_X: body2_x <= cfg_data;
          REG_SECOND_Y: body2_y <= cfg_data;
          REG_FALLOFF: falloff <= cfg_data[15:0];
          REG_PEAK: peak <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        warped_q.insert(warped_q.size(), warp_vertex(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (warped_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
          errors <= errors + 1;
        end else begin
          exp_w = warped_q.pop_front();
          if (exp_w[23:0] !== m_axis_tdata[23:0] || exp_w[47:24] !== m_axis_tdata[47:24]) begin
            $display("%0t: mismatch, expected x %h y %h, actual x %h y %h", $time,
                     exp_w[23:0], exp_w[47:24], m_axis_tdata[23:0], m_axis_tdata[47:24]);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

### test/two_body_grid_warp_unit_tb.sv
// Testbench top for the two-body grid warp unit: drives register settings
// and vertex words under varied idling; the checker judges the outputs.
// Depends on tbgw_pkg, two_body_grid_warp_unit and its checker.
`default_nettype none

module two_body_grid_warp_unit_tb;
  import tbgw_pkg::*;

  logic clk = 0, rst = 1;
  logic cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 0, s_axis_tready, m_axis_tvalid, m_axis_tready = 0;
  logic [TDATA_W-1:0] s_axis_tdata = '0, m_axis_tdata;
  int errors, pending;
  int send_idle = 0, recv_stall = 0, hold_off = 0;

  two_body_grid_warp_unit dut (.*);
  two_body_grid_warp_unit_chk chk (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver side: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      m_axis_tready <= 0;
      hold_off <= hold_off - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  // Wait for all words out, then let the pipeline drain.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_word(logic [47:0] w);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= w;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom_range(1000000, 0) - 500000);
      default: return 24'($urandom);
    endcase
  endfunction

  // Vertices mostly near the bodies so the falloff is exercised.
  function automatic logic [23:0] near(logic [23:0] b, int span);
    return 24'(b + $urandom_range(2 * span) - span);
  endfunction

  initial begin
    logic [23:0] b1x, b1y, b2x, b2y, vx, vy;
    int span;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: extremes and vertices on the bodies under reset settings.
    send_word({24'h800000, 24'h800000});
    send_word({24'h7FFFFF, 24'h7FFFFF});
    send_word({24'h800000, 24'h7FFFFF});
    send_word({24'h7FFFFF, 24'h800000});
    send_word({24'd128000, 24'd204800});
    send_word({24'd128000, 24'd303206});
    send_word({24'd128000, 24'd250000});
    send_word(48'd0);
    s_axis_tvalid <= 0;
    drain();
    // Zero peak, then zero falloff, then strongest pull with saturation.
    write_reg(REG_PEAK, 24'd0);
    send_word({24'd100, 24'd200000});
    s_axis_tvalid <= 0;
    drain();
    write_reg(REG_PEAK, 24'hFFFF);
    write_reg(REG_FALLOFF, 24'd0);
    send_word({24'd100, 24'd200000});
    s_axis_tvalid <= 0;
    drain();
    write_reg(REG_FALLOFF, 24'hFFFF);
    write_reg(REG_FIRST_X, 24'h7FFFFF);
    write_reg(REG_FIRST_Y, 24'h7FFFFF);
    write_reg(REG_SECOND_X, 24'h7FFFFF);
    write_reg(REG_SECOND_Y, 24'h800000);
    send_word({24'h000000, 24'h7FFF00});
    send_word({24'h7FFF00, 24'h800000});
    send_word({24'h800000, 24'h800000});
    s_axis_tvalid <= 0;
    drain();
    write_reg(REG_FIRST_X, 24'h800000);
    write_reg(REG_SECOND_X, 24'h800000);
    send_word({24'h7FFFFF, 24'h7FFFFF});
    send_word({24'h800000, 24'h7FFFFF});
    s_axis_tvalid <= 0;
    drain();
    // Random phases: new settings each time, with idling profiles rotating.
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 51; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 51; end
        default: begin send_idle = 8; recv_stall = 8; end
      endcase
      b1x = rand_coord(ph % 5); b1y = rand_coord((ph + 2) % 5);
      b2x = rand_coord((ph + 1) % 5); b2y = rand_coord((ph + 3) % 5);
      write_reg(REG_FIRST_X, b1x);
      write_reg(REG_FIRST_Y, b1y);
      write_reg(REG_SECOND_X, b2x);
      write_reg(REG_SECOND_Y, b2y);
      write_reg(REG_FALLOFF,
                (ph == 5) ? 24'd1 : (ph == 9) ? 24'hFFFF : 24'($urandom_range(4000, 1)));
      write_reg(REG_PEAK, (ph == 6) ? 24'hFFFF : 24'($urandom_range(65535)));
      write_reg(cfg_reg_t'(3'd6), 24'($urandom));
      write_reg(cfg_reg_t'(3'd7), 24'($urandom));
      if (ph == 2) hold_off = 300;
      for (int i = 0; i < 125; i++) begin
        span = ($urandom_range(3) == 0) ? 2000000 : 300000;
        case ($urandom_range(9))
          0: begin vx = 24'($urandom); vy = 24'($urandom); end
          1: begin vx = rand_coord($urandom_range(1)); vy = rand_coord($urandom_range(1)); end
          2, 3, 4: begin vx = near(b1x, span); vy = near(b1y, span); end
          default: begin vx = near(b2x, span); vy = near(b2y, span); end
        endcase
        send_word({vy, vx});
      end
      s_axis_tvalid <= 0;
      drain();
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
